// File: hw/rtl/slpi_pkg.sv
package slpi_pkg;

  // event codes carried in the input tuser
  typedef enum logic [2:0] {
    KIND_TICK        = 3'd0,
    KIND_BEGIN       = 3'd1,
    KIND_END_BOOT    = 3'd2,
    KIND_ACTIVITY    = 3'd3,
    KIND_SET_UNSAVED = 3'd4,
    KIND_SET_SAVING  = 3'd5,
    KIND_ERROR       = 3'd6,
    KIND_REFRESH     = 3'd7
  } kind_t;

  // indicator states, lower code wins
  typedef enum logic [2:0] {
    ST_BOOT      = 3'd0,
    ST_ERROR     = 3'd1,
    ST_SAVING    = 3'd2,
    ST_UNSAVED   = 3'd3,
    ST_CONNECTED = 3'd4,
    ST_NORMAL    = 3'd5
  } led_state_t;

  // configuration register indexes
  localparam logic [1:0] REG_CONNECTED_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_SAVING_HOLD       = 2'd1;
  localparam logic [1:0] REG_ERROR_HOLD        = 2'd2;
  localparam logic [1:0] REG_LED_PRESENT       = 2'd3;

  localparam int unsigned HoldW = 16;
  localparam logic [7:0] FULL = 8'd255;

  typedef struct packed {
    logic [HoldW-1:0] connected_timeout_ms;
    logic [HoldW-1:0] saving_hold_ms;
    logic [HoldW-1:0] error_hold_ms;
    logic             led_present;
  } cfg_t;

  typedef struct packed {
    logic  latch_ready;
    logic  flag;
    kind_t kind;
  } item_t;

  typedef struct packed {
    logic       ready_for_command;
    logic       show;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    led_state_t led_state;
  } result_t;

  // color of each state as {red, green, blue}
  function automatic logic [23:0] state_color(led_state_t st);
    logic [23:0] c;
    case (st)
      ST_BOOT:      c = {FULL, FULL, FULL};
      ST_ERROR:     c = {FULL, 8'd0, 8'd0};
      ST_SAVING:    c = {FULL, 8'd0, FULL};
      ST_UNSAVED:   c = {FULL, FULL, 8'd0};
      ST_CONNECTED: c = {8'd0, FULL, 8'd0};
      default:      c = {8'd0, 8'd0, FULL};
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/slpi_cfg.sv
module slpi_cfg
  import slpi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [1:0]       wr_index,
  input  logic [HoldW-1:0] wr_data,
  output cfg_t             cfg
);

  cfg_t cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.connected_timeout_ms <= 16'd1000;
      cfg_r.saving_hold_ms       <= 16'd500;
      cfg_r.error_hold_ms        <= 16'd2000;
      cfg_r.led_present          <= 1'b1;
    end else if (wr_en) begin
      case (wr_index)
        REG_CONNECTED_TIMEOUT: cfg_r.connected_timeout_ms <= wr_data;
        REG_SAVING_HOLD:       cfg_r.saving_hold_ms       <= wr_data;
        REG_ERROR_HOLD:        cfg_r.error_hold_ms        <= wr_data;
        REG_LED_PRESENT:       cfg_r.led_present          <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hw/rtl/slpi_core.sv
module slpi_core
  import slpi_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  logic             boot_phase_r, boot_phase_nxt;
  logic             unsaved_r, unsaved_nxt;
  logic             saving_r, saving_nxt;
  logic             shown_once_r, shown_once_nxt;
  logic [HoldW-1:0] conn_left_r, conn_left_nxt;
  logic [HoldW-1:0] save_left_r, save_left_nxt;
  logic [HoldW-1:0] err_left_r, err_left_nxt;
  led_state_t       last_shown_r, last_shown_nxt;
  led_state_t       st;
  logic             update;
  logic             show;
  logic [23:0]      rgb;

  // event decode and flag / countdown update
  always_comb begin
    boot_phase_nxt = boot_phase_r;
    unsaved_nxt    = unsaved_r;
    saving_nxt     = saving_r;
    conn_left_nxt  = conn_left_r;
    save_left_nxt  = save_left_r;
    err_left_nxt   = err_left_r;
    update         = 1'b0;
    case (item.kind)
      KIND_TICK: begin
        if (conn_left_r != '0) conn_left_nxt = conn_left_r - 1'b1;
        if (save_left_r != '0) save_left_nxt = save_left_r - 1'b1;
        if (err_left_r != '0)  err_left_nxt  = err_left_r - 1'b1;
      end
      KIND_BEGIN: begin
        boot_phase_nxt = 1'b1;
        unsaved_nxt    = 1'b0;
        saving_nxt     = 1'b0;
        conn_left_nxt  = '0;
        save_left_nxt  = '0;
        err_left_nxt   = '0;
        update         = 1'b1;
      end
      KIND_END_BOOT: begin
        boot_phase_nxt = 1'b0;
        update         = 1'b1;
      end
      KIND_ACTIVITY:    conn_left_nxt = cfg.connected_timeout_ms;
      KIND_SET_UNSAVED: unsaved_nxt   = item.flag;
      KIND_SET_SAVING: begin
        saving_nxt = item.flag;
        if (item.flag) save_left_nxt = cfg.saving_hold_ms;
        update = 1'b1;
      end
      KIND_ERROR: err_left_nxt = cfg.error_hold_ms;
      default:    update = 1'b1;
    endcase
  end

  // priority select on the updated state
  always_comb begin
    if (boot_phase_nxt)                         st = ST_BOOT;
    else if (err_left_nxt != '0)                st = ST_ERROR;
    else if (saving_nxt || save_left_nxt != '0) st = ST_SAVING;
    else if (unsaved_nxt)                       st = ST_UNSAVED;
    else if (conn_left_nxt != '0)               st = ST_CONNECTED;
    else                                        st = ST_NORMAL;
  end

  // show strobe; begin drops the shown-once mark before the check
  always_comb begin
    logic once;
    once = (item.kind == KIND_BEGIN) ? 1'b0 : shown_once_r;
    show = update && cfg.led_present &&
           (!once || (st != last_shown_r && item.latch_ready));
    shown_once_nxt = show ? 1'b1 : once;
    last_shown_nxt = show ? st : last_shown_r;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boot_phase_r <= 1'b1;
      unsaved_r    <= 1'b0;
      saving_r     <= 1'b0;
      shown_once_r <= 1'b0;
      conn_left_r  <= '0;
      save_left_r  <= '0;
      err_left_r   <= '0;
      last_shown_r <= ST_BOOT;
    end else if (fire) begin
      boot_phase_r <= boot_phase_nxt;
      unsaved_r    <= unsaved_nxt;
      saving_r     <= saving_nxt;
      shown_once_r <= shown_once_nxt;
      conn_left_r  <= conn_left_nxt;
      save_left_r  <= save_left_nxt;
      err_left_r   <= err_left_nxt;
      last_shown_r <= last_shown_nxt;
    end
  end

  assign rgb = state_color(st);

  always_comb begin
    result.led_state         = st;
    result.red               = rgb[23:16];
    result.green             = rgb[15:8];
    result.blue              = rgb[7:0];
    result.show              = show;
    result.ready_for_command = !cfg.led_present || item.latch_ready;
  end

endmodule

// File: hw/rtl/status_led_priority_indicator.sv
// Status LED priority indicator. Each event transfer on the input stream (kind in
// in_tuser: tick, begin, end of boot, activity, set unsaved, set saving, error,
// refresh) updates the boot, unsaved and saving flags and the three hold countdowns,
// and yields exactly one result transfer: the priority state (boot, error, saving,
// unsaved, connected, normal), its color, a show strobe and ready-for-command.
// The block takes one event per cycle while the output is not stalled; an event passes
// through an input register and a result register, and backpressure on the output
// stalls both. Configuration writes are always accepted.
module status_led_priority_indicator
  import slpi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // event stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] flag, [1] latch_ready
  input  logic [2:0]  in_tuser,   // [2:0] kind
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [2:0] led_state, [10:3] red, [18:11] green,
                                  // [26:19] blue, [27] show, [28] ready_for_command
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  item_t   item_r;
  logic    item_vld_r;
  result_t res;
  result_t res_r;
  logic    res_vld_r;
  logic    adv;

  assign cfg_ready = 1'b1;

  slpi_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // pipeline advance: result slot free or being drained
  assign adv       = item_vld_r && (!res_vld_r || out_tready);
  assign in_tready = !item_vld_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.kind        <= kind_t'(in_tuser);
      item_r.flag        <= in_tdata[0];
      item_r.latch_ready <= in_tdata[1];
    end
  end

  slpi_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (adv),
    .item   (item_r),
    .cfg    (cfg),
    .result (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (adv) begin
      res_vld_r <= 1'b1;
    end else if (out_tready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {3'd0, res_r};

endmodule

// File: verif/status_led_priority_indicator_tb.sv
`timescale 1ns / 100ps

module status_led_priority_indicator_tb
  import slpi_pkg::*;
();

  localparam int unsigned CycleLimit = 300000;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [0] flag, [1] latch_ready
  logic [2:0]  in_tuser   = '0;   // [2:0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [2:0] led_state, [10:3] red, [18:11] green,
                                  // [26:19] blue, [27] show, [28] ready_for_command
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [15:0] cfg_data   = '0;

  // indicator shadow state and register copies
  logic [15:0] conn_timeout, saving_hold, error_hold;
  logic        led_on;
  logic        in_boot, unsaved_on, saving_on, shown_once;
  logic [15:0] conn_left, saving_left, error_left;
  led_state_t  last_shown;

  result_t     pending_results[$];
  result_t     want_result, seen_result;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          sender_busy = 1'b1;

  status_led_priority_indicator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status_led_priority_indicator test failed");
    $finish;
  end

  // state after reset, registers included
  function automatic void reset_indicator();
    conn_timeout = 16'd1000;
    saving_hold  = 16'd500;
    error_hold   = 16'd2000;
    led_on       = 1'b1;
    in_boot      = 1'b1;
    unsaved_on   = 1'b0;
    saving_on    = 1'b0;
    shown_once   = 1'b0;
    conn_left    = '0;
    saving_left  = '0;
    error_left   = '0;
    last_shown   = ST_BOOT;
  endfunction

  // apply one event and queue the result it produces
  function automatic void advance_indicator(kind_t kind, logic flag, logic latch);
    logic       repaint;
    led_state_t st;
    result_t    res;
    repaint = 1'b0;
    case (kind)
      KIND_TICK: begin
        if (conn_left != 0) conn_left--;
        if (saving_left != 0) saving_left--;
        if (error_left != 0) error_left--;
      end
      KIND_BEGIN: begin
        in_boot     = 1'b1;
        unsaved_on  = 1'b0;
        saving_on   = 1'b0;
        conn_left   = '0;
        saving_left = '0;
        error_left  = '0;
        shown_once  = 1'b0;
        repaint     = 1'b1;
      end
      KIND_END_BOOT: begin
        in_boot = 1'b0;
        repaint = 1'b1;
      end
      KIND_ACTIVITY:    conn_left = conn_timeout;
      KIND_SET_UNSAVED: unsaved_on = flag;
      KIND_SET_SAVING: begin
        saving_on = flag;
        if (flag) saving_left = saving_hold;
        repaint = 1'b1;
      end
      KIND_ERROR:       error_left = error_hold;
      default:          repaint = 1'b1;
    endcase

    // priority select
    if (in_boot) st = ST_BOOT;
    else if (error_left != 0) st = ST_ERROR;
    else if (saving_on || saving_left != 0) st = ST_SAVING;
    else if (unsaved_on) st = ST_UNSAVED;
    else if (conn_left != 0) st = ST_CONNECTED;
    else st = ST_NORMAL;

    res.led_state = st;
    res.red   = (st inside {ST_BOOT, ST_ERROR, ST_SAVING, ST_UNSAVED}) ? FULL : 8'd0;
    res.green = (st inside {ST_BOOT, ST_UNSAVED, ST_CONNECTED}) ? FULL : 8'd0;
    res.blue  = (st inside {ST_BOOT, ST_SAVING, ST_NORMAL}) ? FULL : 8'd0;
    res.show  = 1'b0;
    if (repaint && led_on && (!shown_once || (st != last_shown && latch))) begin
      res.show   = 1'b1;
      last_shown = st;
      shown_once = 1'b1;
    end
    res.ready_for_command = !led_on || latch;
    pending_results.push_back(res);
  endfunction

  // one event transfer, with a random gap in front
  task automatic send_event(kind_t kind, logic flag, logic latch);
    int unsigned gap;
    gap = sender_busy ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'd0, latch, flag};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_indicator(kind, flag, latch);
  endtask

  // stop sending and wait until every result is back
  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all four registers, only while idle
  task automatic write_settings(logic [15:0] conn, logic [15:0] sav, logic [15:0] err,
                                logic present);
    logic [1:0]  idx  [4];
    logic [15:0] vals [4];
    idx  = '{REG_CONNECTED_TIMEOUT, REG_SAVING_HOLD, REG_ERROR_HOLD, REG_LED_PRESENT};
    vals = '{conn, sav, err, {15'd0, present}};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid    <= 1'b0;
    conn_timeout = conn;
    saving_hold  = sav;
    error_hold   = err;
    led_on       = present;
  endtask

  // result side: random stall before every transfer, calm stretches in between
  initial begin
    int unsigned stall;
    int unsigned taken;
    bit          busy;
    busy  = 1'b1;
    taken = 0;
    forever begin
      if (taken % 32 == 0) busy = $urandom_range(0, 1);
      stall = busy ? $urandom_range(0, 10) : 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result 0x%08h", $time, out_tdata);
        mismatch_count++;
      end else begin
        want_result = pending_results.pop_front();
        seen_result = result_t'(out_tdata[28:0]);
        if (seen_result.led_state != want_result.led_state) begin
          $display("%0t: led_state expected %0d actual %0d", $time,
                   want_result.led_state, seen_result.led_state);
          mismatch_count++;
        end
        if (seen_result.red != want_result.red) begin
          $display("%0t: red expected %0d actual %0d", $time,
                   want_result.red, seen_result.red);
          mismatch_count++;
        end
        if (seen_result.green != want_result.green) begin
          $display("%0t: green expected %0d actual %0d", $time,
                   want_result.green, seen_result.green);
          mismatch_count++;
        end
        if (seen_result.blue != want_result.blue) begin
          $display("%0t: blue expected %0d actual %0d", $time,
                   want_result.blue, seen_result.blue);
          mismatch_count++;
        end
        if (seen_result.show !== want_result.show) begin
          $display("%0t: show expected %0b actual %0b", $time,
                   want_result.show, seen_result.show);
          mismatch_count++;
        end
        if (seen_result.ready_for_command !== want_result.ready_for_command) begin
          $display("%0t: ready_for_command expected %0b actual %0b", $time,
                   want_result.ready_for_command, seen_result.ready_for_command);
          mismatch_count++;
        end
      end
    end
  end

  // reset register values: first show ignores the latch, boot wins over all
  task automatic test_reset_settings();
    send_event(KIND_REFRESH, 1'b0, 1'b0);
    send_event(KIND_ACTIVITY, 1'b1, 1'b1);
    send_event(KIND_END_BOOT, 1'b0, 1'b1);
    wait_results();
  endtask

  // walk the priority chain with short holds until each one lapses
  task automatic test_priority_chain();
    write_settings(16'd3, 16'd2, 16'd4, 1'b1);
    send_event(KIND_BEGIN, 1'b0, 1'b0);
    send_event(KIND_REFRESH, 1'b0, 1'b1);       // same state, no show
    send_event(KIND_END_BOOT, 1'b0, 1'b0);      // new state but latch busy
    send_event(KIND_END_BOOT, 1'b0, 1'b1);
    send_event(KIND_ACTIVITY, 1'b0, 1'b1);
    send_event(KIND_SET_UNSAVED, 1'b1, 1'b1);
    send_event(KIND_SET_SAVING, 1'b1, 1'b1);
    send_event(KIND_ERROR, 1'b1, 1'b0);
    repeat (4) send_event(KIND_TICK, 1'b0, 1'b1);
    send_event(KIND_SET_SAVING, 1'b0, 1'b1);    // flag clear, hold already gone
    send_event(KIND_SET_UNSAVED, 1'b0, 1'b0);
    send_event(KIND_ACTIVITY, 1'b1, 1'b0);
    repeat (3) send_event(KIND_TICK, 1'b1, 1'b0);
    send_event(KIND_REFRESH, 1'b1, 1'b1);
    wait_results();
  endtask

  // no led: nothing shows, always ready; zero holds never engage
  task automatic test_no_led_zero_holds();
    write_settings(16'd0, 16'd0, 16'd0, 1'b0);
    send_event(KIND_END_BOOT, 1'b0, 1'b0);
    send_event(KIND_ACTIVITY, 1'b0, 1'b0);
    send_event(KIND_ERROR, 1'b0, 1'b0);
    send_event(KIND_SET_SAVING, 1'b1, 1'b0);
    send_event(KIND_SET_SAVING, 1'b0, 1'b1);
    send_event(KIND_REFRESH, 1'b0, 1'b0);
    wait_results();
  endtask

  // random events, ticks most often so holds keep lapsing
  task automatic random_events(int unsigned count);
    int unsigned pick;
    kind_t       kind;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 25 == 0) sender_busy = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 35) kind = KIND_TICK;
      else if (pick < 38) kind = KIND_BEGIN;
      else if (pick < 46) kind = KIND_END_BOOT;
      else kind = kind_t'($urandom_range(3, 7));
      send_event(kind, 1'($urandom_range(0, 1)), ($urandom_range(0, 9) < 7));
    end
  endtask

  task automatic test_random_phases();
    write_settings(16'($urandom_range(1, 30)), 16'($urandom_range(1, 30)),
                   16'($urandom_range(1, 30)), 1'b1);
    random_events(150);
    wait_results();
    write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    random_events(80);
    wait_results();
    write_settings(16'h0000, 16'h0000, 16'h0000, 1'b1);
    random_events(80);
    wait_results();
    write_settings(16'd1, 16'd1, 16'd1, 1'b0);
    random_events(80);
    wait_results();
  endtask

  // sender holds off mid-stream until the block has answered everything
  task automatic test_drain_pause();
    write_settings(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                   16'($urandom_range(1, 12)), 1'b1);
    random_events(80);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    random_events(80);
    wait_results();
  endtask

  initial begin
    reset_indicator();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_settings();
    test_priority_chain();
    test_no_led_zero_holds();
    test_random_phases();
    test_drain_pause();

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status_led_priority_indicator test passed");
    end else begin
      $display("status_led_priority_indicator test failed");
    end
    $finish;
  end

endmodule

// File: status_led_priority_indicator.f
hw/rtl/slpi_pkg.sv
hw/rtl/slpi_cfg.sv
hw/rtl/slpi_core.sv
hw/rtl/status_led_priority_indicator.sv
verif/status_led_priority_indicator_tb.sv
